// ===== rtl/core/chsis_pkg.sv =====
// Shared types, constants and the remainder step for the hash set unit.
`timescale 1ns / 1ps

package chsis_pkg;

  // Table geometry
  localparam int NUM_BUCKETS  = 11;
  localparam int BUCKET_DEPTH = 8;

  // Field widths
  localparam int KEY_W   = 31;
  localparam int OBKT_W  = 4;
  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int CNT_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int ROW_W   = BUCKET_DEPTH * KEY_W;

  // Remainder pipeline in the front: STEP_BITS key bits per stage
  localparam int STEP_BITS    = 8;
  localparam int FRONT_STAGES = (KEY_W + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W        = FRONT_STAGES * STEP_BITS;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Result codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OBKT_W-1:0] bucket;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [BKT_W-1:0] bkt;
  } queue_item_t;

  // One stage of the remainder pipeline
  typedef struct packed {
    logic             action;
    logic [PAD_W-1:0] key;
    logic [BKT_W-1:0] rem;
  } front_stage_t;

  // Restoring remainder by NUM_BUCKETS over STEP_BITS more key bits
  function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0]     rem,
                                                input logic [STEP_BITS-1:0] bits);
    logic [BKT_W:0]   t;
    logic [BKT_W-1:0] r;
    r = rem;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= (BKT_W + 1)'(NUM_BUCKETS)) begin
        t = t - (BKT_W + 1)'(NUM_BUCKETS);
      end
      r = t[BKT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/chsis_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module chsis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/chsis_front.sv =====
// Front end: accepts items and works out the bucket index in a short pipeline.
`timescale 1ns / 1ps

module chsis_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  chsis_pkg::in_item_t    in_item_i,
  output logic                   fq_valid_o,
  input  logic                   fq_stall_i,
  output chsis_pkg::queue_item_t fq_item_o
);
  import chsis_pkg::*;

  front_stage_t stg_q   [FRONT_STAGES];
  front_stage_t stg_d   [FRONT_STAGES];
  front_stage_t stg_src [FRONT_STAGES];
  logic [FRONT_STAGES-1:0] vld_q;
  logic                    advance;

  // Whole pipeline moves unless the last stage is blocked by a full queue
  assign advance    = !(vld_q[FRONT_STAGES-1] && fq_stall_i);
  assign in_stall_o = !advance;

  // Stage inputs, then one remainder step per stage, most significant bits first
  always_comb begin
    stg_src[0].action = in_item_i.action;
    stg_src[0].key    = PAD_W'(in_item_i.key);
    stg_src[0].rem    = '0;
    for (int s = 1; s < FRONT_STAGES; s++) begin
      stg_src[s] = stg_q[s-1];
    end
    for (int s = 0; s < FRONT_STAGES; s++) begin
      stg_d[s]     = stg_src[s];
      stg_d[s].rem = mod_step(stg_src[s].rem,
                              stg_src[s].key[PAD_W-1-s*STEP_BITS -: STEP_BITS]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int s = 0; s < FRONT_STAGES; s++) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], in_valid_i};
    end
  end

  // Hand the classified item to the queue
  assign fq_valid_o       = vld_q[FRONT_STAGES-1];
  assign fq_item_o.action = stg_q[FRONT_STAGES-1].action;
  assign fq_item_o.key    = KEY_W'(stg_q[FRONT_STAGES-1].key);
  assign fq_item_o.bkt    = stg_q[FRONT_STAGES-1].rem;

endmodule

// ===== rtl/core/chsis_fifo.sv =====
// Short queue between the front end and the table engine.
`timescale 1ns / 1ps

module chsis_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_stall_o,
  input  chsis_pkg::queue_item_t push_item_i,
  output logic                   pop_valid_o,
  input  logic                   pop_stall_i,
  output chsis_pkg::queue_item_t pop_item_o
);
  import chsis_pkg::*;

  queue_item_t       slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_stall_o = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slot_q[rptr_q];

  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && !pop_stall_i;

  // Pointer and count update
  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Item storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/chsis_back.sv =====
// Table engine: bucket row read, parallel compare, row and fill count write-back.
`timescale 1ns / 1ps

module chsis_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_stall_o,
  input  chsis_pkg::queue_item_t pop_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output chsis_pkg::out_item_t   out_item_o
);
  import chsis_pkg::*;

  localparam logic BS_IDLE = 1'b0;
  localparam logic BS_EXEC = 1'b1;

  logic              state_q, state_d;
  queue_item_t       cur_q;
  logic [CNT_W-1:0]  fill_q [NUM_BUCKETS];
  logic [CNT_W-1:0]  fill;
  logic [ROW_W-1:0]  row_rd;
  logic [ROW_W-1:0]  row_wr;
  logic              start, exec, full, found, row_we;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q;
  status_e           status;

  // Take the next item only when the output register will be free for it
  assign start       = (state_q == BS_IDLE) && pop_valid_i && (!out_valid_q || !out_stall_i);
  assign exec        = (state_q == BS_EXEC);
  assign pop_stall_o = !start;

  // Bucket rows
  chsis_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (cur_q.bkt),
    .wdata_i (row_wr),
    .re_i    (start),
    .raddr_i (pop_item_i.bkt),
    .rdata_o (row_rd)
  );

  // Compare every filled slot and build the row with the new key in place
  always_comb begin
    fill  = fill_q[cur_q.bkt];
    full  = (fill >= CNT_W'(BUCKET_DEPTH));
    found = 1'b0;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      if ((CNT_W'(i) < fill) && (row_rd[i*KEY_W +: KEY_W] == cur_q.key)) begin
        found = 1'b1;
      end
      row_wr[i*KEY_W +: KEY_W] = (CNT_W'(i) == fill) ? cur_q.key : row_rd[i*KEY_W +: KEY_W];
    end
    row_we = exec && (cur_q.action == ACT_INSERT) && !full;
    if (cur_q.action == ACT_INSERT) begin
      status = full ? ST_FULL : ST_INSERTED;
    end else begin
      status = found ? ST_FOUND : ST_MISSING;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (start) begin
          state_d = BS_EXEC;
        end
      end
      BS_EXEC: begin
        state_d = BS_IDLE;
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Fill counts, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        fill_q[b] <= '0;
      end
    end else if (row_we) begin
      fill_q[cur_q.bkt] <= fill + 1'b1;
    end
  end

  // Item in flight and result register
  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q <= pop_item_i;
    end
    if (exec) begin
      out_item_q.status <= status;
      out_item_q.bucket <= OBKT_W'(cur_q.bkt);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/chained_hash_set_insert_search_unit.sv =====
// Top level of the chained hash set: front end, queue and table engine.
`timescale 1ns / 1ps

// Hash set with fixed-depth buckets, insert and search.
// Input channel (in_valid_i / in_stall_o / in_item_i): an item carries an
// action (insert or search) and a 31-bit key. The bucket is key mod the
// bucket count, worked out in a four-stage remainder pipeline in the front.
// Output channel (out_valid_o / out_stall_i / out_item_o): exactly one result
// per item, in order: inserted, bucket full, found or not found, plus bucket.
// Each item passes the front stages and the queue, and then the engine.
// The engine takes a new item only once it is through with the last, set by
// the bucket row RAM read-modify-write (read, then compare and write back).
// The front keeps taking items into a two-entry queue while the engine works
// or a result waits in the output register.
// Reset clears the bucket fill counts and all valid state; no clearing pass
// is run and the block takes items from the first cycle after reset.
// When the receiver stalls, the result holds; the engine then stops, the
// queue fills and in_stall_o rises once the front pipeline cannot advance.
module chained_hash_set_insert_search_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  chsis_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output chsis_pkg::out_item_t out_item_o
);
  import chsis_pkg::*;

  queue_item_t fq_item, bq_item;
  logic        fq_valid, fq_stall;
  logic        bq_valid, bq_stall;

  chsis_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .fq_valid_o (fq_valid),
    .fq_stall_i (fq_stall),
    .fq_item_o  (fq_item)
  );

  chsis_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_stall_o (fq_stall),
    .push_item_i  (fq_item),
    .pop_valid_o  (bq_valid),
    .pop_stall_i  (bq_stall),
    .pop_item_o   (bq_item)
  );

  chsis_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (bq_valid),
    .pop_stall_o (bq_stall),
    .pop_item_i  (bq_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/core/chsis_checker.sv =====
// Port-level checks for the hash set unit, bound to the top level.
`timescale 1ns / 1ps

module chsis_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input chsis_pkg::in_item_t  in_item_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input chsis_pkg::out_item_t out_item_o
);
  import chsis_pkg::*;

  // A stalled input item stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while stalled");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // The engine takes each item through an idle and an execute state, so results never come back to back
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result followed in the next cycle");

  // Reported bucket lies inside the table
  a_bkt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (NUM_BUCKETS > 16) || (out_item_o.bucket < OBKT_W'(NUM_BUCKETS)))
    else $error("bucket index out of range");

endmodule

bind chained_hash_set_insert_search_unit chsis_checker u_chsis_checker (.*);

// ===== tb/sv/tb_chained_hash_set_insert_search_unit.sv =====
// Self-checking testbench for the chained hash set insert and search unit.
`timescale 1ns / 1ps

module tb_chained_hash_set_insert_search_unit;
  import chsis_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int DRAIN_CYCLES = 12;
  localparam int KEY_MAX = 32'h7FFF_FFFF;
  localparam int unsigned AIM_SPAN = 195_225_785;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Items waiting to be driven, and results still owed by the block
  in_item_t    request_q[$];
  out_item_t   outcome_q[$];
  logic [30:0] key_pool[$];

  // Shadow copy of the table
  logic [KEY_W-1:0] model_keys[NUM_BUCKETS][BUCKET_DEPTH];
  int unsigned      model_fill[NUM_BUCKETS];

  int  idle_pct = 0;
  int  stall_pct = 0;
  int  fail_cnt = 0;
  bit  in_taken = 1'b0;

  chained_hash_set_insert_search_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Work out the result of one item and update the shadow table
  function automatic out_item_t bucket_outcome(in_item_t req);
    int unsigned kv;
    int unsigned b;
    int unsigned n;
    status_e     st;
    out_item_t   res;
    kv = req.key;
    b  = kv % NUM_BUCKETS;
    n  = model_fill[b];
    if (req.action == ACT_INSERT) begin
      if (n >= BUCKET_DEPTH) begin
        st = ST_FULL;
      end else begin
        model_keys[b][n] = req.key;
        model_fill[b]    = n + 1;
        st = ST_INSERTED;
      end
    end else begin
      st = ST_MISSING;
      for (int i = 0; i < n; i++) begin
        if (model_keys[b][i] == req.key) st = ST_FOUND;
      end
    end
    res.status = st;
    res.bucket = b[OBKT_W-1:0];
    return res;
  endfunction

  // Driver: new item or gap at the falling edge, stalls on the output side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_item_i  <= request_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) outcome_q.push_back(bucket_outcome(in_item_i));
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with none pending: status %0d bucket %0d",
                   $time, out_item_o.status, out_item_o.bucket);
          fail_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (out_item_o.status !== want.status) begin
            $display("%0t: status expected %0d got %0d",
                     $time, want.status, out_item_o.status);
            fail_cnt++;
          end
          if (out_item_o.bucket !== want.bucket) begin
            $display("%0t: bucket expected %0d got %0d",
                     $time, want.bucket, out_item_o.bucket);
            fail_cnt++;
          end
        end
      end
    end
  end

  task automatic queue_item(logic act, logic [30:0] key);
    in_item_t it;
    it.action = act;
    it.key    = key;
    request_q.push_back(it);
    if (act == ACT_INSERT) key_pool.push_back(key);
  endtask

  // Key that lands in a chosen bucket, spread over the whole key range
  function automatic logic [30:0] aimed_key(int unsigned b);
    int unsigned kv;
    kv = $urandom_range(AIM_SPAN) * NUM_BUCKETS + b;
    return kv[30:0];
  endfunction

  function automatic logic [30:0] fresh_key();
    int unsigned kv;
    kv = $urandom;
    return kv[30:0];
  endfunction

  task automatic queue_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        case ($urandom_range(3))
          0: queue_item(ACT_INSERT, fresh_key());
          1: queue_item(ACT_INSERT, aimed_key($urandom_range(NUM_BUCKETS - 1)));
          2: begin
            if (key_pool.size() != 0) begin
              queue_item(ACT_INSERT, key_pool[$urandom_range(key_pool.size() - 1)]);
            end else begin
              queue_item(ACT_INSERT, fresh_key());
            end
          end
          default: queue_item(ACT_INSERT, 31'($urandom_range(120)));
        endcase
      end else if (r < 75 && key_pool.size() != 0) begin
        queue_item(ACT_SEARCH, key_pool[$urandom_range(key_pool.size() - 1)]);
      end else if (r < 88) begin
        queue_item(ACT_SEARCH, aimed_key($urandom_range(NUM_BUCKETS - 1)));
      end else begin
        queue_item(ACT_SEARCH, fresh_key());
      end
    end
  endtask

  // Hold off until every queued item is taken and every result has come
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (request_q.size() != 0 || in_valid_i || outcome_q.size() != 0);
  endtask

  // Stimulus sequence
  initial begin
    for (int b = 0; b < NUM_BUCKETS; b++) model_fill[b] = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty bucket, duplicates, extreme keys, top bucket, full bucket
    queue_item(ACT_SEARCH, 31'd1);
    queue_item(ACT_INSERT, 31'd0);
    queue_item(ACT_INSERT, 31'd0);
    queue_item(ACT_SEARCH, 31'd0);
    queue_item(ACT_INSERT, 31'(KEY_MAX));
    queue_item(ACT_SEARCH, 31'(KEY_MAX));
    queue_item(ACT_SEARCH, 31'd11);
    queue_item(ACT_INSERT, 31'd10);
    queue_item(ACT_SEARCH, 31'h2AAA_AAAA);
    queue_item(ACT_INSERT, 31'h5555_5555);
    for (int i = 0; i < BUCKET_DEPTH + 1; i++) queue_item(ACT_INSERT, 31'(5 + 11 * i));
    queue_item(ACT_SEARCH, 31'(5 + 11 * (BUCKET_DEPTH - 1)));
    queue_item(ACT_SEARCH, 31'(5 + 11 * BUCKET_DEPTH));
    queue_item(ACT_SEARCH, 31'h5555_5555);
    queue_item(ACT_SEARCH, 31'd10);
    wait_idle();

    // Random phases: free running, sender gaps, receiver stalls, both
    queue_random(230);
    wait_idle();
    idle_pct = 71;
    queue_random(230);
    wait_idle();
    idle_pct  = 0;
    stall_pct = 71;
    queue_random(230);
    wait_idle();
    idle_pct  = 28;
    stall_pct = 28;
    queue_random(230);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    #1;
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("chained_hash_set_insert_search_unit test passed");
    end else begin
      $display("chained_hash_set_insert_search_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("chained_hash_set_insert_search_unit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/chsis_pkg.sv
rtl/core/chsis_ram.sv
rtl/core/chsis_front.sv
rtl/core/chsis_fifo.sv
rtl/core/chsis_back.sv
rtl/core/chained_hash_set_insert_search_unit.sv
rtl/core/chsis_checker.sv
tb/sv/tb_chained_hash_set_insert_search_unit.sv
